>>> rtl/topic_model_gibbs_resampler_core_assert.svh
// Assertion macros shared by the resampler RTL.
`ifndef TOPIC_MODEL_GIBBS_RESAMPLER_CORE_ASSERT_SVH
`define TOPIC_MODEL_GIBBS_RESAMPLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMG_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tmg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TMG_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("tmg assertion failed");

`endif

>>> rtl/tmg_pkg.sv
// ----------------------------------------------------------------------------
// tmg_pkg
// Shared sizes, codes and types of the topic resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmg_pkg;

    localparam int NUM_TOPICS  = 128;
    localparam int VOCAB_SIZE  = 16384;
    localparam int DOC_COUNT   = 4096;

    localparam int TOPIC_W = $clog2(NUM_TOPICS);
    localparam int TK_W    = TOPIC_W + 1;
    localparam int VOCAB_W = $clog2(VOCAB_SIZE);
    localparam int DOC_W   = $clog2(DOC_COUNT);

    localparam int WORD_DEPTH = NUM_TOPICS * VOCAB_SIZE;
    localparam int DOC_DEPTH  = NUM_TOPICS * DOC_COUNT;
    localparam int WORD_AW    = TOPIC_W + VOCAB_W;
    localparam int DOC_AW     = TOPIC_W + DOC_W;
    localparam int CLR_LEN    = (WORD_DEPTH > DOC_DEPTH) ? WORD_DEPTH : DOC_DEPTH;
    localparam int CLR_W      = $clog2(CLR_LEN);

    // port field widths
    localparam int DOC_FW   = 12;
    localparam int WORD_FW  = 14;
    localparam int TOPIC_FW = 7;
    localparam int DRAW_W   = 16;

    // count and fixed point widths
    localparam int WCNT_W   = 20;
    localparam int DCNT_W   = 16;
    localparam int TCNT_W   = 24;
    localparam int FRAC_W   = 16;
    localparam int PRIOR_W  = 24;
    localparam int BTOT_W   = 32;
    localparam int A_W      = WCNT_W + FRAC_W + 1;
    localparam int B_W      = DCNT_W + FRAC_W + 1;
    localparam int DEN_W    = TCNT_W + FRAC_W + 1;
    localparam int PROD_W   = A_W + B_W;
    localparam int Q_W      = 32;
    localparam int PLO_W    = Q_W + B_W;
    localparam int SUM_W    = 48;

    // divider: two quotient bits per cycle
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = Q_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = QPTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOPICS     = 2'd0,
        REG_ALPHA      = 2'd1,
        REG_BETA       = 2'd2,
        REG_BETA_TOTAL = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD     = 1'b0,
        OP_RESAMPLE = 1'b1
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [DOC_W-1:0]   doc;
        logic [VOCAB_W-1:0] word;
        logic [TOPIC_W-1:0] topic;
        logic [DRAW_W-1:0]  draw;
    } item_t;

    typedef struct packed {
        logic [TK_W-1:0]    k;
        logic [PRIOR_W-1:0] alpha;
        logic [PRIOR_W-1:0] beta;
        logic [BTOT_W-1:0]  beta_total;
    } cfg_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

>>> rtl/tmg_ram.sv
// ----------------------------------------------------------------------------
// tmg_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/tmg_front.sv
// ----------------------------------------------------------------------------
// tmg_front
// Command intake, configuration registers and the word queue to the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "topic_model_gibbs_resampler_core_assert.svh"

module tmg_front import tmg_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  operation,
    input  logic [DOC_FW-1:0]     doc_index,
    input  logic [WORD_FW-1:0]    word_index,
    input  logic [TOPIC_FW-1:0]   current_topic,
    input  logic [DRAW_W-1:0]     uniform_draw,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  clearing,
    input  logic                  pop,
    output head_t                 head,
    output cfg_t                  cfg
);

    logic [7:0]         topics_reg;
    logic [PRIOR_W-1:0] alpha_reg;
    logic [PRIOR_W-1:0] beta_reg;
    logic [BTOT_W-1:0]  btot_reg;

    item_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;

    logic  push;
    item_t in_item;
    logic [TK_W-1:0] k_clamp;

    assign busy = clearing || (cnt_reg == QCNT_W'(QDEPTH));
    assign push = start && !busy;

    // indices wrap to the built store sizes
    assign in_item.op    = op_t'(operation);
    assign in_item.doc   = doc_index[DOC_W-1:0];
    assign in_item.word  = word_index[VOCAB_W-1:0];
    assign in_item.topic = current_topic[TOPIC_W-1:0];
    assign in_item.draw  = uniform_draw;

    assign head.valid = (cnt_reg != '0);
    assign head.item  = q_reg[rd_ptr_reg];

    always_comb
    begin
        if (topics_reg == 8'd0)
        begin
            k_clamp = TK_W'(1);
        end
        else if (TK_W'(topics_reg) > TK_W'(NUM_TOPICS))
        begin
            k_clamp = TK_W'(NUM_TOPICS);
        end
        else
        begin
            k_clamp = TK_W'(topics_reg);
        end
    end
    assign cfg.k          = k_clamp;
    assign cfg.alpha      = alpha_reg;
    assign cfg.beta       = beta_reg;
    assign cfg.beta_total = btot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topics_reg <= 8'd100;
            alpha_reg  <= PRIOR_W'(32768);
            beta_reg   <= PRIOR_W'(655);
            btot_reg   <= BTOT_W'(13107200);
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TOPICS:     topics_reg <= cfg_data[7:0];
                REG_ALPHA:      alpha_reg  <= cfg_data[PRIOR_W-1:0];
                REG_BETA:       beta_reg   <= cfg_data[PRIOR_W-1:0];
                REG_BETA_TOTAL: btot_reg   <= cfg_data[BTOT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    `TMG_ASSERT_NXT(a_push_fills, clk, rst_n, push, cnt_reg != '0)
    `TMG_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, cnt_reg != '0)

endmodule

>>> rtl/tmg_div.sv
// ----------------------------------------------------------------------------
// tmg_div
// Restoring divider, two quotient bits per cycle, quotient held to 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "topic_model_gibbs_resampler_core_assert.svh"

module tmg_div import tmg_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [Q_W-1:0]    quo
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [Q_W-1:0]    low_reg;

    logic [DEN_W-1:0]  rem_step;
    logic [Q_W-1:0]    low_step;
    logic [DEN_W:0]    rem_wide;
    logic [PROD_W-Q_W-1:0] num_hi;
    logic              ovf;

    assign num_hi = num[PROD_W-1:Q_W];
    // quotient needs more than 32 bits (zero divisor included)
    assign ovf    = ({{(DEN_W+1){1'b0}}, num_hi} >= {{(PROD_W-Q_W+1){1'b0}}, den});

    always_comb
    begin
        rem_step = rem_reg;
        low_step = low_reg;
        rem_wide = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            rem_wide = {rem_step, low_step[Q_W-1]};
            low_step = {low_step[Q_W-2:0], 1'b0};
            if (rem_wide >= {1'b0, den_reg})
            begin
                rem_wide    = rem_wide - {1'b0, den_reg};
                low_step[0] = 1'b1;
            end
            rem_step = rem_wide[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                if (ovf)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= DEN_W'(num_hi);
            low_reg <= ovf ? '1 : num[Q_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            low_reg <= low_step;
        end
    end

    assign done = done_reg;
    assign quo  = low_reg;

    `TMG_ASSERT_IMP(a_start_idle, clk, rst_n, start, !busy_reg)
    `TMG_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg)

endmodule

>>> rtl/tmg_back.sv
// ----------------------------------------------------------------------------
// tmg_back
// Count stores, topic weighing walk, threshold scan and count update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "topic_model_gibbs_resampler_core_assert.svh"

module tmg_back import tmg_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  head_t               head,
    input  cfg_t                cfg,
    output logic                pop,
    output logic                clearing,
    output logic                done,
    output logic [TOPIC_FW-1:0] new_topic,
    output logic                count_saturated
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DEC_RD, S_DEC_WR, S_W_RD, S_W_DATA, S_W_MUL1,
        S_W_MUL2, S_W_DSTART, S_W_DIV, S_THR, S_SCAN, S_INC_RD, S_INC_WR
    } state_t;

    state_t state_reg, state_next;
    item_t  it_reg, it_next;
    logic [CLR_W-1:0]   clr_reg, clr_next;
    logic [TK_W-1:0]    t_reg, t_next;
    logic [TOPIC_W-1:0] top_reg, top_next;
    logic [A_W-1:0]     a_reg, a_next;
    logic [B_W-1:0]     b_reg, b_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [PLO_W-1:0]   plo_reg, plo_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUM_W-1:0]   thr_reg, thr_next;
    logic [TK_W-1:0]    scan_reg, scan_next;
    logic [TK_W-1:0]    tag_reg, tag_next;
    logic               svld_reg, svld_next;
    logic               done_reg, done_next;
    logic [TOPIC_W-1:0] nt_reg, nt_next;
    logic               sat_reg, sat_next;

    logic               cnt_we, rw_we, div_start, div_done;
    logic [Q_W-1:0]     div_q;
    logic [TOPIC_W-1:0] rd_topic;
    logic [WCNT_W-1:0]  wc_rd, wc_wd, wc_dec, wc_inc;
    logic [DCNT_W-1:0]  dc_rd, dc_wd, dc_dec, dc_inc;
    logic [TCNT_W-1:0]  tc_rd, tc_wd, tc_dec, tc_inc;
    logic [SUM_W-1:0]   rw_rd;
    logic [WORD_AW-1:0] wc_waddr;
    logic [DOC_AW-1:0]  dc_waddr;
    logic [TOPIC_W-1:0] tc_waddr;
    logic               dc_we, tc_we, inc_sat;
    logic [SUM_W+DRAW_W-1:0] thr_prod;
    logic [TK_W-1:0]    k_last;

    assign clearing = (state_reg == S_CLEAR);
    assign rd_topic = (state_reg == S_W_RD) ? t_reg[TOPIC_W-1:0] : top_reg;
    assign k_last   = cfg.k - 1'b1;

    // counts held at zero going down and at full scale going up
    assign wc_dec = (wc_rd == '0) ? '0 : wc_rd - 1'b1;
    assign dc_dec = (dc_rd == '0) ? '0 : dc_rd - 1'b1;
    assign tc_dec = (tc_rd == '0) ? '0 : tc_rd - 1'b1;
    assign wc_inc = (wc_rd == '1) ? wc_rd : wc_rd + 1'b1;
    assign dc_inc = (dc_rd == '1) ? dc_rd : dc_rd + 1'b1;
    assign tc_inc = (tc_rd == '1) ? tc_rd : tc_rd + 1'b1;
    assign inc_sat = (wc_rd == '1) || (dc_rd == '1) || (tc_rd == '1);

    assign cnt_we = clearing || (state_reg == S_DEC_WR) || (state_reg == S_INC_WR);
    assign dc_we  = clearing ? (clr_reg < CLR_W'(DOC_DEPTH - 1)) ||
                               (clr_reg == CLR_W'(DOC_DEPTH - 1)) : cnt_we;
    assign tc_we  = clearing ? (clr_reg < CLR_W'(NUM_TOPICS)) : cnt_we;
    assign wc_waddr = clearing ? clr_reg[WORD_AW-1:0] : {top_reg, it_reg.word};
    assign dc_waddr = clearing ? clr_reg[DOC_AW-1:0] : {top_reg, it_reg.doc};
    assign tc_waddr = clearing ? clr_reg[TOPIC_W-1:0] : top_reg;
    assign wc_wd = clearing ? '0 : ((state_reg == S_DEC_WR) ? wc_dec : wc_inc);
    assign dc_wd = clearing ? '0 : ((state_reg == S_DEC_WR) ? dc_dec : dc_inc);
    assign tc_wd = clearing ? '0 : ((state_reg == S_DEC_WR) ? tc_dec : tc_inc);

    assign thr_prod = sum_reg * it_reg.draw;

    tmg_ram #(.WIDTH(WCNT_W), .DEPTH(WORD_DEPTH)) u_word_ram (
        .clk(clk), .we(cnt_we), .waddr(wc_waddr), .wdata(wc_wd),
        .raddr({rd_topic, it_reg.word}), .rdata(wc_rd)
    );

    tmg_ram #(.WIDTH(DCNT_W), .DEPTH(DOC_DEPTH)) u_doc_ram (
        .clk(clk), .we(dc_we), .waddr(dc_waddr), .wdata(dc_wd),
        .raddr({rd_topic, it_reg.doc}), .rdata(dc_rd)
    );

    tmg_ram #(.WIDTH(TCNT_W), .DEPTH(NUM_TOPICS)) u_total_ram (
        .clk(clk), .we(tc_we), .waddr(tc_waddr), .wdata(tc_wd),
        .raddr(rd_topic), .rdata(tc_rd)
    );

    tmg_ram #(.WIDTH(SUM_W), .DEPTH(NUM_TOPICS)) u_sum_ram (
        .clk(clk), .we(rw_we), .waddr(t_reg[TOPIC_W-1:0]), .wdata(sum_next),
        .raddr(scan_reg[TOPIC_W-1:0]), .rdata(rw_rd)
    );

    tmg_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(prod_reg),
        .den(den_reg), .done(div_done), .quo(div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        it_next    = it_reg;
        clr_next   = clr_reg;
        t_next     = t_reg;
        top_next   = top_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        den_next   = den_reg;
        plo_next   = plo_reg;
        prod_next  = prod_reg;
        sum_next   = sum_reg;
        thr_next   = thr_reg;
        scan_next  = scan_reg;
        tag_next   = tag_reg;
        svld_next  = svld_reg;
        done_next  = 1'b0;
        nt_next    = nt_reg;
        sat_next   = sat_reg;
        pop        = 1'b0;
        rw_we      = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(CLR_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    it_next    = head.item;
                    top_next   = head.item.topic;
                    state_next = (head.item.op == OP_RESAMPLE) ? S_DEC_RD : S_INC_RD;
                end
            end
            S_DEC_RD:
            begin
                state_next = S_DEC_WR;
            end
            S_DEC_WR:
            begin
                t_next     = '0;
                sum_next   = '0;
                state_next = S_W_RD;
            end
            S_W_RD:
            begin
                state_next = S_W_DATA;
            end
            S_W_DATA:
            begin
                a_next   = A_W'({wc_rd, {FRAC_W{1'b0}}}) + A_W'(cfg.beta);
                b_next   = B_W'({dc_rd, {FRAC_W{1'b0}}}) + B_W'(cfg.alpha);
                den_next = DEN_W'({tc_rd, {FRAC_W{1'b0}}}) + DEN_W'(cfg.beta_total);
                state_next = S_W_MUL1;
            end
            S_W_MUL1:
            begin
                plo_next   = a_reg[Q_W-1:0] * b_reg;
                state_next = S_W_MUL2;
            end
            S_W_MUL2:
            begin
                prod_next  = PROD_W'(plo_reg) +
                             (PROD_W'(a_reg[A_W-1:Q_W] * b_reg) << Q_W);
                state_next = S_W_DSTART;
            end
            S_W_DSTART:
            begin
                div_start  = 1'b1;
                state_next = S_W_DIV;
            end
            S_W_DIV:
            begin
                if (div_done)
                begin
                    rw_we    = 1'b1;
                    sum_next = sum_reg + SUM_W'(div_q);
                    if (t_reg == k_last)
                    begin
                        state_next = S_THR;
                    end
                    else
                    begin
                        t_next     = t_reg + 1'b1;
                        state_next = S_W_RD;
                    end
                end
            end
            S_THR:
            begin
                thr_next   = thr_prod[SUM_W+DRAW_W-1:FRAC_W];
                scan_next  = '0;
                svld_next  = 1'b0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // one read issued per cycle, data checked in the next cycle
                svld_next = (scan_reg < cfg.k);
                tag_next  = scan_reg;
                if (scan_reg < cfg.k)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                if (svld_reg && ((rw_rd > thr_reg) || (tag_reg == k_last)))
                begin
                    top_next   = tag_reg[TOPIC_W-1:0];
                    state_next = S_INC_RD;
                end
            end
            S_INC_RD:
            begin
                state_next = S_INC_WR;
            end
            S_INC_WR:
            begin
                done_next  = 1'b1;
                nt_next    = top_reg;
                sat_next   = inc_sat;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            svld_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            svld_reg  <= svld_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg   <= it_next;
        t_reg    <= t_next;
        top_reg  <= top_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        den_reg  <= den_next;
        plo_reg  <= plo_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        thr_reg  <= thr_next;
        scan_reg <= scan_next;
        tag_reg  <= tag_next;
        nt_reg   <= nt_next;
        sat_reg  <= sat_next;
    end

    assign done            = done_reg;
    assign new_topic       = TOPIC_FW'(nt_reg);
    assign count_saturated = sat_reg;

    `TMG_ASSERT_NXT(a_done_single, clk, rst_n, done_reg, !done_reg)
    `TMG_ASSERT_IMP(a_no_pop_clear, clk, rst_n, clearing, !pop)
    `TMG_ASSERT_NXT(a_div_after_start, clk, rst_n, div_start, state_reg == S_W_DIV)

endmodule

>>> rtl/topic_model_gibbs_resampler_core.sv
// ----------------------------------------------------------------------------
// topic_model_gibbs_resampler_core
// Collapsed Gibbs topic resampler with on-chip count stores.
// ----------------------------------------------------------------------------
// After reset the block sweeps its count stores to zero with busy high
// (configuration writes are taken during that time). A load word reads
// and then writes back its incremented counts. A resample's time for K
// active topics is set by the per-topic weigh walk, whose radix-4 divider
// saturates a weight that overflows and skips its steps, then by a
// one-entry-a-cycle scan of the running sums. A two-word queue lets start
// be taken while a word is in flight; busy rises when it is full. Each
// result appears on new_topic and count_saturated with done high for one
// cycle, and those two outputs hold their value until the next result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module topic_model_gibbs_resampler_core import tmg_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  operation,
    input  logic [DOC_FW-1:0]     doc_index,
    input  logic [WORD_FW-1:0]    word_index,
    input  logic [TOPIC_FW-1:0]   current_topic,
    input  logic [DRAW_W-1:0]     uniform_draw,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [TOPIC_FW-1:0]   new_topic,
    output logic                  count_saturated
);

    head_t head;
    cfg_t  cfg;
    logic  pop;
    logic  clearing;

    tmg_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .doc_index(doc_index), .word_index(word_index),
        .current_topic(current_topic), .uniform_draw(uniform_draw),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .clearing(clearing), .pop(pop), .head(head), .cfg(cfg)
    );

    tmg_back u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .cfg(cfg), .pop(pop),
        .clearing(clearing), .done(done), .new_topic(new_topic),
        .count_saturated(count_saturated)
    );

endmodule
